@@ sv/ultrasonic_echo_ranger_assert.svh @@
// assertion macros shared by the ranger rtl
// no dependencies; included by the modules that check themselves
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// checked property, idle while reset is low
`define UER_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication form, same clocking
`define UER_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/uer_pkg.sv @@
// types and constants of the echo ranger
// used by every module of the block; no dependencies
package uer_pkg;

  localparam int TICK_W  = 17;
  localparam int TRIG_W  = 10;
  localparam int WIDTH_W = 16;
  localparam int WHOLE_W = 11;
  localparam int HUND_W  = 7;
  localparam int REM_W   = 6;

  // register map, indexed by paddr[2]
  localparam logic CFG_TRIGGER_WIDTH = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [TRIG_W-1:0] TRIG_RESET    = 10'd12;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 17'd65536;

  // w / 58 as (w * 72316) >> 22, exact for 16 bit w
  localparam logic [16:0] DIV58_MUL   = 17'd72316;
  localparam int          DIV58_SHIFT = 22;
  // v / 58 as (v * 1130) >> 16, exact for v below 5830
  localparam logic [10:0] HUND_MUL    = 11'd1130;
  localparam int          HUND_SHIFT  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic {
    PH_IDLE,
    PH_MEASURE
  } uer_phase_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_WIDTH,
    RES_TIMEOUT
  } uer_res_t;

  // classified tick from the front end
  typedef struct packed {
    logic               trig;
    logic               busy;
    uer_res_t           res;
    logic [WIDTH_W-1:0] width;
  } uer_rec_t;

  typedef struct packed {
    logic               trig;
    logic               busy;
    logic               done;
    logic               no_echo;
    logic [WIDTH_W-1:0] width;
    logic [WHOLE_W-1:0] whole;
    logic [HUND_W-1:0]  hund;
  } uer_out_t;

endpackage

@@ sv/uer_front.sv @@
// front end: tick counter, trigger timing, echo edge detection
// depends on uer_pkg; feeds classified records to the queue
module uer_front
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              action,
  input  logic              echo,
  input  logic [TRIG_W-1:0] trigger_width,
  input  logic [TICK_W-1:0] timeout_ticks,
  output uer_rec_t          rec
);

  localparam int WLIM_INT = (COUNTER_BITS >= WIDTH_W) ? ((1 << WIDTH_W) - 1)
                                                      : ((1 << COUNTER_BITS) - 1);
  localparam logic [TICK_W-1:0] WIDTH_LIMIT = TICK_W'(WLIM_INT);

  uer_phase_t        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] rise_r, rise_nxt;
  logic              echo_prev_r, echo_prev_nxt;
  logic              edge_seen_r, edge_seen_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] diff;
  logic              timed_out;
  logic              edge_hit;

  assign tick_inc  = tick_r + TICK_W'(1);
  assign timed_out = tick_inc >= timeout_ticks;
  assign edge_hit  = echo != echo_prev_r;
  assign diff      = tick_inc - rise_r;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (accept && action) phase_nxt = PH_MEASURE;
      end
      PH_MEASURE: begin
        if (accept && !action && (timed_out || (edge_hit && edge_seen_r)))
          phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    tick_nxt      = tick_r;
    rise_nxt      = rise_r;
    echo_prev_nxt = echo_prev_r;
    edge_seen_nxt = edge_seen_r;
    rec.res       = RES_NONE;
    rec.width     = (diff > WIDTH_LIMIT) ? WIDTH_LIMIT[WIDTH_W-1:0] : diff[WIDTH_W-1:0];
    unique case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          echo_prev_nxt = echo;
          if (action) begin
            tick_nxt      = '0;
            rise_nxt      = '0;
            edge_seen_nxt = 1'b0;
          end
        end
      end
      PH_MEASURE: begin
        // a start while measuring leaves everything alone
        if (accept && !action) begin
          tick_nxt      = tick_inc;
          echo_prev_nxt = echo;
          if (timed_out) begin
            rec.res = RES_TIMEOUT;
          end else if (edge_hit) begin
            if (!edge_seen_r) begin
              rise_nxt      = tick_inc;
              edge_seen_nxt = 1'b1;
            end else begin
              rec.res = RES_WIDTH;
            end
          end
        end
      end
      default: ;
    endcase
    rec.busy = phase_nxt == PH_MEASURE;
    rec.trig = rec.busy && (tick_nxt < {{(TICK_W-TRIG_W){1'b0}}, trigger_width});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      rise_r      <= '0;
      echo_prev_r <= 1'b0;
      edge_seen_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      rise_r      <= rise_nxt;
      echo_prev_r <= echo_prev_nxt;
      edge_seen_r <= edge_seen_nxt;
    end
  end

endmodule

@@ sv/uer_queue.sv @@
// short queue between front and back end
// depends on uer_pkg and the assertion macros header
`include "ultrasonic_echo_ranger_assert.svh"
module uer_queue
  import uer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  uer_rec_t wr_rec,
  output logic     full,
  input  logic     pop,
  output uer_rec_t rd_rec,
  output logic     empty
);

  uer_rec_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full   = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty  = count_r == '0;
  assign rd_rec = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `UER_ASSERT(a_count_range, clk, rst_n, count_r <= (QPTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
  `UER_ASSERT(a_no_push_full, clk, rst_n, !(push && full), "push into full queue")
  `UER_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && empty), "pop from empty queue")

endmodule

@@ sv/uer_back.sv @@
// back end: divide width by 58, hundredths, hold last measurement
// depends on uer_pkg and the assertion macros header
`include "ultrasonic_echo_ranger_assert.svh"
module uer_back
  import uer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  uer_rec_t q_rec,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output uer_out_t out_beat
);

  logic adv;

  logic               v1_r, v2_r, v3_r;
  uer_rec_t           rec1_r, rec2_r, rec3_r;
  logic [WHOLE_W-1:0] quo1_r, quo2_r, quo3_r;
  logic [REM_W-1:0]   rem2_r;
  logic [HUND_W-1:0]  hund3_r;

  logic               out_valid_r;
  uer_out_t           out_r, out_nxt;

  logic [33:0]        quo_prod;
  logic [16:0]        quo_x58;
  logic [12:0]        hund_v;
  logic [23:0]        hund_prod;

  // whole pipeline moves together; holds when a result beat is stalled
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign quo_prod  = {17'b0, q_rec.width} * {17'b0, DIV58_MUL};
  assign quo_x58   = {6'b0, quo1_r} * 17'd58;
  assign hund_v    = 13'(rem2_r) * 13'd100 + 13'd29;
  assign hund_prod = {11'b0, hund_v} * {13'b0, HUND_MUL};

  always_comb begin
    out_nxt      = out_r;
    out_nxt.trig = rec3_r.trig;
    out_nxt.busy = rec3_r.busy;
    out_nxt.done = rec3_r.res != RES_NONE;
    case (rec3_r.res)
      RES_WIDTH: begin
        out_nxt.no_echo = 1'b0;
        out_nxt.width   = rec3_r.width;
        out_nxt.whole   = quo3_r;
        out_nxt.hund    = hund3_r;
      end
      RES_TIMEOUT: begin
        out_nxt.no_echo = 1'b1;
        out_nxt.width   = '0;
        out_nxt.whole   = '0;
        out_nxt.hund    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec1_r  <= q_rec;
      quo1_r  <= quo_prod[DIV58_SHIFT +: WHOLE_W];
      rec2_r  <= rec1_r;
      quo2_r  <= quo1_r;
      rem2_r  <= REM_W'(rec1_r.width - quo_x58[WIDTH_W-1:0]);
      rec3_r  <= rec2_r;
      quo3_r  <= quo2_r;
      hund3_r <= hund_prod[HUND_SHIFT +: HUND_W];
    end
  end

  // the result register also keeps the last measurement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else if (adv) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
      if (v3_r) out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  `UER_ASSERT(a_hund_range, clk, rst_n, out_r.hund <= HUND_W'(99), "hundredths out of range")
  `UER_ASSERT_IMP(a_no_echo_zero, clk, rst_n, out_r.no_echo,
                  (out_r.width == '0) && (out_r.whole == '0) && (out_r.hund == '0),
                  "timed-out result carries a width")
  `UER_ASSERT(a_quotient, clk, rst_n,
              ({6'b0, out_r.width} >= {6'b0, out_r.whole} * 17'd58) &&
              ({6'b0, out_r.width} < {6'b0, out_r.whole} * 17'd58 + 17'd58),
              "width over 58 mismatch")

endmodule

@@ sv/ultrasonic_echo_ranger.sv @@
// ultrasonic echo ranger top level: config registers, front, queue, back
// depends on uer_pkg, uer_front, uer_queue, uer_back
//
//  channel | dir | handshake                | fields
//  in_     | in  | tvalid/tready            | tuser: action; tdata: echo
//  out_    | out | tvalid/tready            | tuser: no_echo; tdata: trig..hundredths
//  cfg_    | in  | psel/penable/pready      | trigger_width @0, timeout_ticks @4
//
// one tick beat is taken every cycle while the queue is not full; a taken tick beat
// passes the queue slot written at the accepting edge, then quotient multiply, remainder,
// hundredths multiply and result register, after which out_tvalid rises
// the four-entry queue absorbs result stalls; in_tready drops only when it is full
// rst_n is synchronous: measurement idle, last result zero, registers at defaults
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] echo
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] trigger_out, [1] busy_res, [2] done_res,
                                  // [18:3] echo_width, [29:19] distance_whole,
                                  // [36:30] distance_hundredths
  output logic        out_tuser,  // [0] no_echo
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [TRIG_W-1:0] trig_width_r;
  logic [TICK_W-1:0] timeout_r;
  logic              cfg_wr;

  logic     in_accept;
  uer_rec_t front_rec;
  logic     q_full, q_empty, q_pop;
  uer_rec_t q_rec;
  uer_out_t out_beat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_width_r <= TRIG_RESET;
      timeout_r    <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_TRIGGER_WIDTH: trig_width_r <= cfg_pwdata[TRIG_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_r    <= cfg_pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_TRIGGER_WIDTH: cfg_prdata = {{(32-TRIG_W){1'b0}}, trig_width_r};
      CFG_TIMEOUT_TICKS: cfg_prdata = {{(32-TICK_W){1'b0}}, timeout_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  uer_front #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .action        (in_tuser),
    .echo          (in_tdata[0]),
    .trigger_width (trig_width_r),
    .timeout_ticks (timeout_r),
    .rec           (front_rec)
  );

  uer_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_accept),
    .wr_rec (front_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_rec),
    .empty  (q_empty)
  );

  uer_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_beat  (out_beat)
  );

  assign out_tdata = {3'b0, out_beat.hund, out_beat.whole, out_beat.width,
                      out_beat.done, out_beat.busy, out_beat.trig};
  assign out_tuser = out_beat.no_echo;

endmodule

@@ dv/ultrasonic_echo_ranger_test.sv @@
// self-checking bench for ultrasonic_echo_ranger: tick and start beats in, readings out
// a small scoreboard predicts each reading; plain tasks drive the stream and apb ports
// depends on uer_pkg and the ranger rtl
module ultrasonic_echo_ranger_test
  import uer_pkg::*;
;

  localparam int RANGE_BITS    = 16;
  localparam int SAT_WIDTH     = (RANGE_BITS >= 16) ? 65535 : (1 << RANGE_BITS) - 1;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BEATS  = 560;
  localparam int CALM_BEATS    = 100;
  localparam int US_PER_CM     = 58;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  class ranger_scoreboard;
    logic [TRIG_W-1:0]  trig_len;
    logic [TICK_W-1:0]  limit_ticks;
    uer_phase_t         phase;
    logic [TICK_W-1:0]  ticks;
    logic [TICK_W-1:0]  rise_at;
    logic               echo_was;
    logic               rise_seen;
    logic [WIDTH_W-1:0] held_width;
    logic [WHOLE_W-1:0] held_whole;
    logic [HUND_W-1:0]  held_hund;
    logic               held_no_echo;
    int                 sat_width;
    int                 errors;
    uer_out_t           expected_readings[$];

    function new(int sat);
      sat_width    = sat;
      trig_len     = TRIG_RESET;
      limit_ticks  = TIMEOUT_RESET;
      phase        = PH_IDLE;
      ticks        = '0;
      rise_at      = '0;
      echo_was     = 1'b0;
      rise_seen    = 1'b0;
      held_width   = '0;
      held_whole   = '0;
      held_hund    = '0;
      held_no_echo = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == CFG_TRIGGER_WIDTH) begin
        trig_len = value[TRIG_W-1:0];
      end else begin
        limit_ticks = value[TICK_W-1:0];
      end
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // one accepted beat gives exactly one reading
    function void log_beat(logic action, logic echo);
      uer_out_t          want;
      logic [TICK_W-1:0] span;
      int                w;
      want = '0;
      if (phase != PH_IDLE) begin
        if (action == ACT_TICK) begin
          ticks = ticks + 1'b1;
          // timeout wins over an edge on the same tick
          if (ticks >= limit_ticks) begin
            phase        = PH_IDLE;
            want.done    = 1'b1;
            held_no_echo = 1'b1;
            held_width   = '0;
            held_whole   = '0;
            held_hund    = '0;
          end else if (echo != echo_was) begin
            if (!rise_seen) begin
              rise_at   = ticks;
              rise_seen = 1'b1;
            end else begin
              span         = ticks - rise_at;
              w            = (int'(span) > sat_width) ? sat_width : int'(span);
              held_width   = WIDTH_W'(w);
              held_whole   = WHOLE_W'(w / US_PER_CM);
              held_hund    = HUND_W'(((w % US_PER_CM) * 100 + US_PER_CM / 2) / US_PER_CM);
              held_no_echo = 1'b0;
              phase        = PH_IDLE;
              want.done    = 1'b1;
            end
          end
          echo_was = echo;
        end
      end else begin
        if (action == ACT_START) begin
          phase     = PH_MEASURE;
          ticks     = '0;
          rise_at   = '0;
          rise_seen = 1'b0;
        end
        echo_was = echo;
      end
      want.busy    = (phase != PH_IDLE);
      want.trig    = want.busy && (ticks < TICK_W'(trig_len));
      want.no_echo = held_no_echo;
      want.width   = held_width;
      want.whole   = held_whole;
      want.hund    = held_hund;
      expected_readings.push_back(want);
    endfunction

    function void report(string what, uer_out_t want, uer_out_t got);
      errors++;
      if (errors <= 10) begin
        $display("ranger: %s: expected trig %b busy %b done %b no_echo %b width %0d",
                 what, want.trig, want.busy, want.done, want.no_echo, want.width);
        $display("ranger:   expected whole %0d hund %0d", want.whole, want.hund);
        $display("ranger:   got trig %b busy %b done %b no_echo %b width %0d",
                 got.trig, got.busy, got.done, got.no_echo, got.width);
        $display("ranger:   got whole %0d hund %0d", got.whole, got.hund);
      end
    endfunction

    function void check_reading(logic [39:0] data, logic no_echo_bit);
      uer_out_t got;
      uer_out_t want;
      got.trig    = data[0];
      got.busy    = data[1];
      got.done    = data[2];
      got.no_echo = no_echo_bit;
      got.width   = data[18:3];
      got.whole   = data[29:19];
      got.hund    = data[36:30];
      if (expected_readings.size() == 0) begin
        report("reading with none outstanding", '0, got);
        return;
      end
      want = expected_readings.pop_front();
      if (got.trig !== want.trig || got.busy !== want.busy || got.done !== want.done ||
          got.no_echo !== want.no_echo || got.width !== want.width ||
          got.whole !== want.whole || got.hund !== want.hund)
        report("reading mismatch", want, got);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;  // [0] echo
  logic        in_tuser    = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;  // [0] trigger_out, [1] busy_res, [2] done_res, [18:3] echo_width,
                           // [29:19] distance_whole, [36:30] distance_hundredths
  logic        out_tuser;  // [0] no_echo
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ranger_scoreboard sb;
  int  beats         = 0;
  int  cycle_count   = 0;
  int  gap_pct       = 0;
  int  out_stall_pct = 0;
  bit  calm          = 1'b0;
  int  stall_left    = 0;
  int  run_left      = 0;

  ultrasonic_echo_ranger #(.COUNTER_BITS(RANGE_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reading side: check accepted beats, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reading(out_tdata, out_tuser);
    if (stall_left == 0 && run_left == 0) begin
      if (!calm && $urandom_range(0, 99) < out_stall_pct) stall_left = $urandom_range(1, 12);
      else run_left = $urandom_range(1, 24);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      run_left--;
      out_tready <= 1'b1;
    end
  end

  task automatic send_beat(logic action, logic echo);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {7'd0, echo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.log_beat(action, echo);
    beats++;
  endtask

  task automatic noisy_tick(logic lvl, int noise);
    if ($urandom_range(0, 99) < noise)
      send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else send_beat(ACT_TICK, lvl);
  endtask

  // start, quiet lead, echo pulse, quiet tail; noise may break the sequence
  task automatic range_once(int lead, int pulse, int tail, int noise);
    logic lvl;
    lvl = 1'($urandom_range(0, 1));
    send_beat(ACT_START, lvl);
    repeat (lead) noisy_tick(lvl, noise);
    repeat (pulse) noisy_tick(~lvl, noise);
    repeat (tail) noisy_tick(lvl, noise);
  endtask

  // two opposite echo levels always finish a running measurement
  task automatic close_out();
    while (sb.busy()) send_beat(ACT_TICK, ~sb.echo_was);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_up(int trig_len, int limit_ticks);
    close_out();
    drain();
    write_reg(CFG_TRIGGER_WIDTH, trig_len);
    write_reg(CFG_TIMEOUT_TICKS, limit_ticks);
  endtask

  initial begin
    int rand_start;
    int limit_ticks;
    int pulse;
    int pick;
    sb = new(SAT_WIDTH);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: idle ticks, ignored starts, spurious level while busy, a short pulse
    gap_pct       = 20;
    out_stall_pct = 30;
    send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_START, 1'b0);
    repeat (3) send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_START, 1'b1);
    send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_TICK, 1'b1);
    repeat (5) send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_START, 1'b1);
    send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_TICK, 1'b0);

    // no trigger at all, and a timeout on the first tick
    set_up(0, 0);
    send_beat(ACT_START, 1'b1);
    send_beat(ACT_TICK, 1'b0);
    // timeout and edge on the same tick, then the narrowest pulse
    set_up(1, 3);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_TICK, 1'b0);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_TICK, 1'b0);

    // widest trigger with the widest timeout value
    set_up(1023, 17'h1FFFF);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_TICK, 1'b1);
    repeat (20) send_beat(ACT_TICK, 1'b1);
    send_beat(ACT_TICK, 1'b0);

    rand_start = beats;
    while (beats - rand_start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 5);
      limit_ticks = (pick == 0) ? 65536 : (pick == 1) ? 1 : $urandom_range(8, 200);
      pick = $urandom_range(0, 5);
      set_up((pick == 0) ? 1 : (pick == 1) ? 1023 : $urandom_range(1, 40), limit_ticks);
      pick          = $urandom_range(0, 2);
      gap_pct       = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
      pick          = $urandom_range(0, 2);
      out_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
      repeat ($urandom_range(2, 6)) begin
        if (beats - rand_start >= RANDOM_BEATS) break;
        if (beats - rand_start >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(4, 16))
            send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          pick = $urandom_range(0, 19);
          if (pick == 0 && limit_ticks != 65536) pulse = 0;
          else if (pick < 3) pulse = $urandom_range(100, 400);
          else pulse = $urandom_range(1, 100);
          range_once($urandom_range(0, 30), pulse, $urandom_range(1, 6),
                     ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(5, 20));
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/uer_pkg.sv
sv/uer_front.sv
sv/uer_queue.sv
sv/uer_back.sv
sv/ultrasonic_echo_ranger.sv
dv/ultrasonic_echo_ranger_test.sv
